@@ rtl/bfsa_pkg.sv @@
package bfsa_pkg;

  localparam int DATA_W   = 64;
  localparam int OFFSET_W = 16;
  localparam int WIDTH_W  = 7;
  localparam int SIZE_W   = 17;
  localparam int SHIFT_W  = 6;
  localparam int WIDX_W   = OFFSET_W - SHIFT_W;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(65536);
  localparam logic [WIDTH_W-1:0] MAX_FIELD  = WIDTH_W'(DATA_W);

  typedef enum logic {
    FUNC_EXTRACT = 1'b0,
    FUNC_INSERT  = 1'b1
  } func_t;

  typedef logic [DATA_W-1:0] word_t;

endpackage

@@ rtl/bfsa_in_if.sv @@
interface bfsa_in_if;
  import bfsa_pkg::*;

  logic                valid;
  logic                ready;
  func_t               func;
  logic [OFFSET_W-1:0] bit_offset;
  logic [WIDTH_W-1:0]  field_width;
  word_t               write_value;

  modport source (output valid, func, bit_offset, field_width, write_value, input ready);
  modport sink   (input valid, func, bit_offset, field_width, write_value, output ready);

endinterface

@@ rtl/bfsa_out_if.sv @@
interface bfsa_out_if;
  import bfsa_pkg::*;

  logic  valid;
  logic  ready;
  word_t read_value;
  logic  ok;

  modport source (output valid, read_value, ok, input ready);
  modport sink   (input valid, read_value, ok, output ready);

endinterface

@@ rtl/bit_field_store_access_unit.sv @@
// Channel  | Dir | Words carried
// ---------+-----+--------------------------------------------------------
// in_if    | in  | func, bit_offset, field_width, write_value
// out_if   | out | read_value, ok (one word per input word, in order)
// cfg_*    | in  | size_in_bits, written when cfg_we is high
//
// One word per cycle sustained while out_if.ready is high: the store is split
// into even and odd word banks, so the one or two words of a field are read in
// the accept cycle and written back when the modify stage advances; a write to
// the entry read by the following word is forwarded. A word passes the modify
// and output registers on its way to out_if.valid. After reset a clearing pass
// zeroes both banks, in_if.ready low. A stalled output holds the stage behind it.
module bit_field_store_access_unit #(
  parameter int NUM_WORDS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bfsa_in_if.sink                       in_if,
  bfsa_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [bfsa_pkg::SIZE_W-1:0]   cfg_wdata
);
  import bfsa_pkg::*;

  localparam int BANK_DEPTH = (NUM_WORDS + 1) / 2;
  localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [22:0]     CAP_BITS = 23'(NUM_WORDS * DATA_W);
  localparam logic [BA_W-1:0] CLR_LAST = BA_W'(BANK_DEPTH - 1);

  word_t even_mem [BANK_DEPTH];
  word_t odd_mem  [BANK_DEPTH];

  logic [SIZE_W-1:0] size_r;
  logic              clr_busy_r;
  logic [BA_W-1:0]   clr_addr_r;

  // accept stage
  logic                accept;
  logic [SIZE_W-1:0]   end_bits;
  logic                req_ok;
  logic [WIDX_W-1:0]   word_idx;
  logic [BA_W-1:0]     rd_even_addr;
  logic [BA_W-1:0]     rd_odd_addr;
  logic [SHIFT_W-1:0]  req_shift;
  word_t               req_mask;
  logic                req_span;

  // modify stage
  logic                s1_valid_r;
  func_t               s1_func_r;
  logic                s1_ok_r;
  logic [SHIFT_W-1:0]  s1_shift_r;
  word_t               s1_mask_r;
  word_t               s1_wval_r;
  logic                s1_odd_r;
  logic                s1_span_r;
  logic [BA_W-1:0]     s1_even_addr_r;
  logic [BA_W-1:0]     s1_odd_addr_r;
  logic                fwd_even_r;
  logic                fwd_odd_r;
  word_t               fwd_even_data_r;
  word_t               fwd_odd_data_r;
  word_t               even_rdata_r;
  word_t               odd_rdata_r;

  logic                s1_adv;
  word_t               even_word;
  word_t               odd_word;
  word_t               lo_word;
  word_t               hi_word;
  logic [2*DATA_W-1:0] joined;
  logic [2*DATA_W-1:0] ins_mask;
  logic [2*DATA_W-1:0] ins_val;
  word_t               new_lo;
  word_t               new_hi;
  word_t               ext_value;
  logic                do_insert;
  logic                we_even;
  logic                we_odd;
  word_t               wdata_even;
  word_t               wdata_odd;

  // output register
  logic                out_valid_r;
  word_t               out_value_r;
  logic                out_ok_r;

  // memory write port select
  logic                mem_we_even;
  logic                mem_we_odd;
  logic [BA_W-1:0]     mem_wa_even;
  logic [BA_W-1:0]     mem_wa_odd;
  word_t               mem_wd_even;
  word_t               mem_wd_odd;

  assign s1_adv      = !out_valid_r || out_if.ready;
  assign in_if.ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    logic [15:0] odd_a16;
    logic [15:0] even_a16;
    logic [7:0]  span_sum;
    end_bits  = {1'b0, in_if.bit_offset} + SIZE_W'(in_if.field_width);
    req_ok    = (in_if.field_width != '0) && (in_if.field_width <= MAX_FIELD) &&
                (end_bits <= size_r) && (23'(end_bits) <= CAP_BITS);
    word_idx  = in_if.bit_offset[OFFSET_W-1:SHIFT_W];
    req_shift = in_if.bit_offset[SHIFT_W-1:0];
    odd_a16   = 16'(word_idx[WIDX_W-1:1]);
    even_a16  = odd_a16 + 16'(word_idx[0]);
    rd_odd_addr  = odd_a16[BA_W-1:0];
    rd_even_addr = even_a16[BA_W-1:0];
    span_sum  = 8'(req_shift) + 8'(in_if.field_width);
    req_span  = span_sum > 8'(DATA_W);
    if (in_if.field_width >= MAX_FIELD) begin
      req_mask = '1;
    end else begin
      req_mask = (word_t'(1) << in_if.field_width) - word_t'(1);
    end
  end

  always_comb begin
    even_word = fwd_even_r ? fwd_even_data_r : even_rdata_r;
    odd_word  = fwd_odd_r  ? fwd_odd_data_r  : odd_rdata_r;
    lo_word   = s1_odd_r ? odd_word  : even_word;
    hi_word   = s1_odd_r ? even_word : odd_word;
    joined    = {hi_word, lo_word} >> s1_shift_r;
    ext_value = joined[DATA_W-1:0] & s1_mask_r;
    ins_mask  = {{DATA_W{1'b0}}, s1_mask_r} << s1_shift_r;
    ins_val   = {{DATA_W{1'b0}}, s1_wval_r} << s1_shift_r;
    new_lo    = (lo_word & ~ins_mask[DATA_W-1:0]) | ins_val[DATA_W-1:0];
    new_hi    = (hi_word & ~ins_mask[2*DATA_W-1:DATA_W]) | ins_val[2*DATA_W-1:DATA_W];
    do_insert = s1_valid_r && s1_adv && s1_ok_r && (s1_func_r == FUNC_INSERT);
    // the low word sits in the odd bank when the field starts in an odd word
    we_even    = do_insert && (!s1_odd_r || s1_span_r);
    we_odd     = do_insert && (s1_odd_r || s1_span_r);
    wdata_even = s1_odd_r ? new_hi : new_lo;
    wdata_odd  = s1_odd_r ? new_lo : new_hi;
  end

  always_comb begin
    if (clr_busy_r) begin
      mem_we_even = 1'b1;
      mem_we_odd  = 1'b1;
      mem_wa_even = clr_addr_r;
      mem_wa_odd  = clr_addr_r;
      mem_wd_even = '0;
      mem_wd_odd  = '0;
    end else begin
      mem_we_even = we_even;
      mem_we_odd  = we_odd;
      mem_wa_even = s1_even_addr_r;
      mem_wa_odd  = s1_odd_addr_r;
      mem_wd_even = wdata_even;
      mem_wd_odd  = wdata_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we_even) begin
      even_mem[mem_wa_even] <= mem_wd_even;
    end
    if (mem_we_odd) begin
      odd_mem[mem_wa_odd] <= mem_wd_odd;
    end
    if (accept) begin
      even_rdata_r <= even_mem[rd_even_addr];
      odd_rdata_r  <= odd_mem[rd_odd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r     <= SIZE_RESET;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + BA_W'(1);
        if (clr_addr_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload of the modify stage; catch the write-back that misses the read just issued
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r       <= in_if.func;
      s1_ok_r         <= req_ok;
      s1_shift_r      <= req_shift;
      s1_mask_r       <= req_mask;
      s1_wval_r       <= in_if.write_value & req_mask;
      s1_odd_r        <= word_idx[0];
      s1_span_r       <= req_span;
      s1_even_addr_r  <= rd_even_addr;
      s1_odd_addr_r   <= rd_odd_addr;
      fwd_even_r      <= we_even && (s1_even_addr_r == rd_even_addr);
      fwd_odd_r       <= we_odd && (s1_odd_addr_r == rd_odd_addr);
      fwd_even_data_r <= wdata_even;
      fwd_odd_data_r  <= wdata_odd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_ok_r    <= s1_ok_r;
      out_value_r <= (s1_ok_r && (s1_func_r == FUNC_EXTRACT)) ? ext_value : '0;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.read_value = out_value_r;
  assign out_if.ok         = out_ok_r;

endmodule

@@ tb/bit_field_store_access_unit_tb.sv @@
module bit_field_store_access_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfsa_pkg::*;

  localparam int STORE_WORDS = 1024;
  localparam int STORE_BITS  = STORE_WORDS * DATA_W;

  typedef enum logic {
    STEP_REQUEST  = 1'b0,
    STEP_SET_SIZE = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [SIZE_W-1:0]   size_val;
    func_t               func;
    logic [OFFSET_W-1:0] offs;
    logic [WIDTH_W-1:0]  fwidth;
    word_t               wval;
    logic                typed;
    word_t               rv;
    logic                ok;
  } plan_step_t;

  typedef struct {
    word_t read_value;
    logic  ok;
  } field_result_t;

  localparam plan_step_t DIRECTED_PLAN [27] = '{
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd0,     7'd64,  64'd0, 1'b1, 64'd0, 1'b1},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd0,     7'd64,  '1,    1'b1, 64'd0, 1'b1},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd0,     7'd64,  64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd60,    7'd8,   64'hA5, 1'b1, 64'd0, 1'b1},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd56,    7'd16,  64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd5,     7'd0,   64'd0, 1'b1, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd5,     7'd0,   '1,    1'b1, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd0,     7'd127, 64'd0, 1'b1, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd0,     7'd65,  '1,    1'b1, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd65535, 7'd1,   64'd1, 1'b1, 64'd0, 1'b1},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd65535, 7'd1,   64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd65535, 7'd2,   64'd0, 1'b1, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd65472, 7'd64,
      64'h0123_4567_89AB_CDEF, 1'b1, 64'd0, 1'b1},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd65472, 7'd64,  64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd184,   7'd8,   64'hFF, 1'b1, 64'd0, 1'b1},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd184,   7'd16,  64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd127,   7'd64,
      64'hFEDC_BA98_7654_3210, 1'b1, 64'd0, 1'b1},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd127,   7'd64,  64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_SET_SIZE, 17'd0, FUNC_EXTRACT, 16'd0,     7'd0,   64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd0,     7'd1,   64'd0, 1'b1, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd0,     7'd1,   64'd0, 1'b1, 64'd0, 1'b0},
    '{STEP_SET_SIZE, 17'd1, FUNC_EXTRACT, 16'd0,     7'd0,   64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd0,     7'd1,   64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_INSERT,  16'd0,     7'd2,   '1,    1'b1, 64'd0, 1'b0},
    '{STEP_SET_SIZE, 17'h1FFFF, FUNC_EXTRACT, 16'd0, 7'd0,   64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd65472, 7'd64,  64'd0, 1'b0, 64'd0, 1'b0},
    '{STEP_REQUEST,  17'd0, FUNC_EXTRACT, 16'd65535, 7'd2,   64'd0, 1'b1, 64'd0, 1'b0}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  bfsa_in_if  in_if();
  bfsa_out_if out_if();

  bit_field_store_access_unit #(
    .NUM_WORDS(STORE_WORDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  word_t             store_mirror [STORE_WORDS];
  logic [SIZE_W-1:0] size_mirror;
  field_result_t     pending_results [$];
  int                fail_count = 0;
  bit                idle_on = 1'b1;

  function automatic field_result_t predict_field_access(func_t f, logic [OFFSET_W-1:0] offs,
                                                         logic [WIDTH_W-1:0] w, word_t wv);
    field_result_t res;
    int            limit;
    int            idx;
    int            sh;
    int            hi;
    word_t         mask;
    word_t         v;
    word_t         lo;
    word_t         up;
    res.read_value = '0;
    res.ok = 1'b0;
    limit = (size_mirror < STORE_BITS) ? int'(size_mirror) : STORE_BITS;
    if (w == 0 || w > MAX_FIELD || int'(offs) + int'(w) > limit) return res;
    idx = int'(offs) / DATA_W;
    sh = int'(offs) % DATA_W;
    mask = (w == MAX_FIELD) ? '1 : (word_t'(1) << w) - 1;
    res.ok = 1'b1;
    if (f == FUNC_EXTRACT) begin
      res.read_value = store_mirror[idx] >> sh;
      if (sh + w > DATA_W) res.read_value |= store_mirror[idx + 1] << (DATA_W - sh);
      res.read_value &= mask;
    end else begin
      v = wv & mask;
      lo = store_mirror[idx] & ~(mask << sh);
      store_mirror[idx] = lo | (v << sh);
      // spill the upper part of the field into the next word
      if (sh + w > DATA_W) begin
        hi = sh + w - DATA_W;
        up = store_mirror[idx + 1] & ~((word_t'(1) << hi) - 1);
        store_mirror[idx + 1] = up | (v >> (DATA_W - sh));
      end
    end
    return res;
  endfunction

  task automatic send_request(input func_t f, input logic [OFFSET_W-1:0] offs,
                              input logic [WIDTH_W-1:0] w, input word_t wv, input logic typed,
                              input word_t typed_rv, input logic typed_ok);
    field_result_t res;
    if (idle_on && $urandom_range(3, 0) == 0) begin
      repeat ($urandom_range(14, 1)) begin
        @(negedge clk);
        in_if.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_if.valid       = 1'b1;
    in_if.func        = f;
    in_if.bit_offset  = offs;
    in_if.field_width = w;
    in_if.write_value = wv;
    do @(posedge clk); while (!in_if.ready);
    // keep the mirror in step even where the result is typed in
    res = predict_field_access(f, offs, w, wv);
    if (typed) begin
      res.read_value = typed_rv;
      res.ok = typed_ok;
    end
    pending_results.push_back(res);
  endtask

  task automatic set_store_size(input logic [SIZE_W-1:0] sz);
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata   = sz;
    cfg_we      = 1'b1;
    size_mirror = sz;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_random_phase(input logic [SIZE_W-1:0] sz, input int count);
    int          bound;
    int          lim;
    int          w;
    int          offs;
    int          pick;
    int unsigned hot;
    func_t       f;
    word_t       wv;
    set_store_size(sz);
    bound = (sz < STORE_BITS) ? int'(sz) : STORE_BITS;
    hot = $urandom;
    repeat (count) begin
      f = func_t'($urandom_range(1, 0));
      wv = {$urandom, $urandom};
      if ($urandom_range(99, 0) < 15) begin
        pick = $urandom_range(2, 0);
        w = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(127, 65) : $urandom_range(127, 0);
        offs = $urandom_range(65535, 0);
      end else begin
        pick = $urandom_range(7, 0);
        w = (bound < DATA_W) ? bound : DATA_W;
        if (pick == 0) w = 1;
        else if (pick > 2) w = $urandom_range(w, 1);
        lim = bound - w;
        offs = $urandom_range(lim, 0);
        // when the range is wide, crowd half the in-range requests into a 256-bit window to hit read-after-write
        if ($urandom_range(1, 0) == 1 && lim > 256)
          offs = int'(hot % (lim - 255)) + $urandom_range(255, 0);
      end
      send_request(f, offs[OFFSET_W-1:0], w[WIDTH_W-1:0], wv, 1'b0, '0, 1'b0);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      int  hold_left;
      bit  ready_next;
      @(negedge clk);
      if (hold_left <= 0) begin
        ready_next = idle_on ? $urandom_range(1, 0) : 1'b1;
        hold_left = ready_next ? $urandom_range(40, 1) : $urandom_range(14, 1);
        out_if.ready = ready_next;
      end
      hold_left--;
    end
  end

  always @(posedge clk) begin
    field_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: read_value=%h ok=%b", out_if.read_value, out_if.ok);
      end else begin
        want = pending_results.pop_front();
        if (out_if.read_value !== want.read_value || out_if.ok !== want.ok) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: read_value exp %h got %h, ok exp %b got %b",
                     want.read_value, out_if.read_value, want.ok, out_if.ok);
        end
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_EXTRACT;
    in_if.bit_offset  = '0;
    in_if.field_width = '0;
    in_if.write_value = '0;
    foreach (store_mirror[i]) store_mirror[i] = '0;
    size_mirror = SIZE_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].kind == STEP_SET_SIZE)
        set_store_size(DIRECTED_PLAN[i].size_val);
      else
        send_request(DIRECTED_PLAN[i].func, DIRECTED_PLAN[i].offs, DIRECTED_PLAN[i].fwidth,
                     DIRECTED_PLAN[i].wval, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].rv,
                     DIRECTED_PLAN[i].ok);
    end

    run_random_phase(SIZE_W'($urandom_range(4096, 64)), 200);
    run_random_phase(SIZE_RESET, 200);
    run_random_phase(SIZE_W'($urandom_range(200, 1)), 200);
    run_random_phase('1, 200);
    run_random_phase(SIZE_W'($urandom_range(65536, 1)), 200);
    idle_on = 1'b0;
    run_random_phase(SIZE_RESET, 200);

    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
